/* rtl/core/mrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// shared constants, widths and state type of the masked residual correlation
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int DEF_SITE_COUNT_BITS = 20;
	localparam int DEF_FRAC_BITS       = 16;
	localparam int QUEUE_DEPTH         = 2;
	localparam int CORR_BITS           = 16;

	localparam logic CFG_MEAN_A = 1'b0;
	localparam logic CFG_MEAN_B = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} back_state_t;

	// width of the square accumulators
	function automatic int sq_bits(int frac_bits, int site_count_bits);
		int raw;
		raw = 2 * (frac_bits + 3) - 1 + site_count_bits;
		return (raw > 62) ? 62 : raw;
	endfunction

endpackage

/* rtl/core/mrc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_if
// site and result channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface mrc_in_if #(
	parameter int RES_BITS = mrc_pkg::DEF_FRAC_BITS + 2
);
	logic                       valid;
	logic                       ready;
	logic signed [RES_BITS-1:0] resid_a;
	logic signed [RES_BITS-1:0] resid_b;
	logic                       keep_a;
	logic                       keep_b;
	logic                       last_site;

	modport source (output valid, resid_a, resid_b, keep_a, keep_b, last_site, input ready);
	modport sink (input valid, resid_a, resid_b, keep_a, keep_b, last_site, output ready);
endinterface

interface mrc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mrc_pkg::CORR_BITS-1:0] correlation;
	logic                                  undefined;

	modport source (output valid, correlation, undefined, input ready);
	modport sink (input valid, correlation, undefined, output ready);
endinterface

/* rtl/core/mrc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_front
// takes site items, subtracts means, accumulates cross and square sums
// ----------------------------------------------------------------------------
module mrc_front #(
	parameter int SITE_COUNT_BITS = mrc_pkg::DEF_SITE_COUNT_BITS,
	parameter int FRAC_BITS       = mrc_pkg::DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	mrc_in_if.sink sites,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [FRAC_BITS+1:0]   cfg_data,
	input  logic [$clog2(mrc_pkg::QUEUE_DEPTH+1)-1:0] free,
	output logic                   push,
	output logic [mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS):0]   sum_cross,
	output logic [mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS)-1:0] sum_sq_a,
	output logic [mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS)-1:0] sum_sq_b
);
	localparam int RB = FRAC_BITS + 2;
	localparam int SQ = mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS);
	localparam int CB = SQ + 1;
	localparam int PB = 2 * (RB + 1);
	localparam int FB = $clog2(mrc_pkg::QUEUE_DEPTH + 1);

	logic [RB-1:0]          mean_a_q, mean_b_q;
	logic signed [RB:0]     da, db;
	logic signed [PB-1:0]   pc, pa, pb;
	logic                   keep, accept;
	logic                   valid_s1, last_s1;
	logic [PB-1:0]          prod_c_s1, prod_a_s1, prod_b_s1;
	logic [CB-1:0]          sum_c_q;
	logic [SQ-1:0]          sum_a_q, sum_b_q;
	logic [CB:0]            c_ext;
	logic [SQ:0]            a_ext, b_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_a_q <= '0;
			mean_b_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrc_pkg::CFG_MEAN_A: mean_a_q <= cfg_data;
				mrc_pkg::CFG_MEAN_B: mean_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sites.ready = (free > FB'(valid_s1 & last_s1));
	assign accept      = sites.valid & sites.ready;
	assign keep        = sites.keep_a & sites.keep_b;

	assign da = {sites.resid_a[RB-1], sites.resid_a} - $signed({mean_a_q[RB-1], mean_a_q});
	assign db = {sites.resid_b[RB-1], sites.resid_b} - $signed({mean_b_q[RB-1], mean_b_q});
	assign pc = da * db;
	assign pa = da * da;
	assign pb = db * db;

	// stage 1: gated products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= sites.last_site;
			prod_c_s1 <= keep ? pc : '0;
			prod_a_s1 <= keep ? pa : '0;
			prod_b_s1 <= keep ? pb : '0;
		end
	end

	// stage 2: saturating accumulation
	assign c_ext = {sum_c_q[CB-1], sum_c_q} + {{(CB+1-PB){prod_c_s1[PB-1]}}, prod_c_s1};
	assign a_ext = {1'b0, sum_a_q} + {{(SQ+1-PB){1'b0}}, prod_a_s1};
	assign b_ext = {1'b0, sum_b_q} + {{(SQ+1-PB){1'b0}}, prod_b_s1};

	always_comb begin
		if (c_ext[CB] != c_ext[CB-1]) begin
			sum_cross = c_ext[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		end else begin
			sum_cross = c_ext[CB-1:0];
		end
		sum_sq_a = a_ext[SQ] ? '1 : a_ext[SQ-1:0];
		sum_sq_b = b_ext[SQ] ? '1 : b_ext[SQ-1:0];
	end

	assign push = valid_s1 & last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_c_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (push) begin
			sum_c_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (valid_s1) begin
			sum_c_q <= sum_cross;
			sum_a_q <= sum_sq_a;
			sum_b_q <= sum_sq_b;
		end
	end

endmodule

/* rtl/core/mrc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_queue
// short queue of finished sums between front and back
// ----------------------------------------------------------------------------
module mrc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             nonempty,
	output logic [$clog2(mrc_pkg::QUEUE_DEPTH+1)-1:0] free
);
	localparam int DEPTH = mrc_pkg::QUEUE_DEPTH;
	localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FB    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AB-1:0]    wr_q, rd_q;
	logic [FB-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AB'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AB'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign dout     = mem[rd_q];
	assign nonempty = (count_q != '0);
	assign free     = FB'(DEPTH) - count_q;

endmodule

/* rtl/core/mrc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_back
// turns a pair's sums into a Q1.15 correlation: multiply, divide, square root
// ----------------------------------------------------------------------------
module mrc_back #(
	parameter int SITE_COUNT_BITS = mrc_pkg::DEF_SITE_COUNT_BITS,
	parameter int FRAC_BITS       = mrc_pkg::DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic nonempty,
	input  logic [mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS):0]   sum_cross,
	input  logic [mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS)-1:0] sum_sq_a,
	input  logic [mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS)-1:0] sum_sq_b,
	output logic pop,
	mrc_out_if.source results
);
	localparam int SQ    = mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS);
	localparam int CB    = SQ + 1;
	localparam int PW    = 2 * SQ;
	localparam int MW    = 2 * CB;
	localparam int QF    = mrc_pkg::CORR_BITS - 1;
	localparam int SHIFT = 2 * QF;
	localparam int W     = MW + SHIFT;
	localparam int DSTEP = SHIFT + 1;
	localparam int CNTB  = $clog2(CB + 1);

	mrc_pkg::back_state_t state_q, state_d;

	logic [PW-1:0]   acc_p_q, mcand_p_q;
	logic [SQ-1:0]   mplr_p_q;
	logic [MW-1:0]   acc_m_q, mcand_m_q;
	logic [CB-1:0]   mplr_m_q;
	logic [W-1:0]    rem_q, dv_q;
	logic [DSTEP-1:0] d_q;
	logic [QF-1:0]   root_q, bit_q, trial;
	logic [SHIFT-1:0] trial_sq, root_sq;
	logic [CNTB-1:0] cnt_q;
	logic [CB-1:0]   mag;
	logic            neg_q, undef_q, ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			mrc_pkg::ST_IDLE: begin
				if (nonempty) begin
					pop     = 1'b1;
					state_d = (sum_sq_a == '0 || sum_sq_b == '0) ? mrc_pkg::ST_DONE
					                                            : mrc_pkg::ST_MUL;
				end
			end
			mrc_pkg::ST_MUL:  if (cnt_q == '0) state_d = mrc_pkg::ST_DIV;
			mrc_pkg::ST_DIV:  if (cnt_q == '0) state_d = mrc_pkg::ST_SQRT;
			mrc_pkg::ST_SQRT: if (bit_q == '0) state_d = mrc_pkg::ST_DONE;
			mrc_pkg::ST_DONE: if (results.ready) state_d = mrc_pkg::ST_IDLE;
			default: state_d = mrc_pkg::ST_IDLE;
		endcase
	end

	assign mag      = sum_cross[CB-1] ? (~sum_cross + 1'b1) : sum_cross;
	assign ge       = (rem_q >= dv_q);
	assign trial    = root_q | bit_q;
	assign trial_sq = trial * trial;
	assign root_sq  = root_q * root_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			mrc_pkg::ST_IDLE: begin
				neg_q     <= sum_cross[CB-1];
				undef_q   <= (sum_sq_a == '0 || sum_sq_b == '0);
				acc_p_q   <= '0;
				mcand_p_q <= {{(PW-SQ){1'b0}}, sum_sq_a};
				mplr_p_q  <= sum_sq_b;
				acc_m_q   <= '0;
				mcand_m_q <= {{(MW-CB){1'b0}}, mag};
				mplr_m_q  <= mag;
				cnt_q     <= CNTB'(CB);
			end
			mrc_pkg::ST_MUL: begin
				if (cnt_q == '0) begin
					rem_q <= {acc_m_q, {SHIFT{1'b0}}};
					dv_q  <= {{(MW-PW){1'b0}}, acc_p_q, {SHIFT{1'b0}}};
					cnt_q <= CNTB'(DSTEP);
				end else begin
					if (mplr_p_q[0]) acc_p_q <= acc_p_q + mcand_p_q;
					if (mplr_m_q[0]) acc_m_q <= acc_m_q + mcand_m_q;
					mcand_p_q <= mcand_p_q << 1;
					mcand_m_q <= mcand_m_q << 1;
					mplr_p_q  <= mplr_p_q >> 1;
					mplr_m_q  <= mplr_m_q >> 1;
					cnt_q     <= cnt_q - 1'b1;
				end
			end
			mrc_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					root_q <= '0;
					bit_q  <= {1'b1, {(QF-1){1'b0}}};
				end else begin
					if (ge) rem_q <= rem_q - dv_q;
					d_q   <= {d_q[DSTEP-2:0], ge};
					dv_q  <= dv_q >> 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			mrc_pkg::ST_SQRT: begin
				if (bit_q != '0) begin
					if (trial_sq <= d_q[SHIFT-1:0]) root_q <= trial;
					bit_q <= bit_q >> 1;
				end
			end
			mrc_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	// zero if undefined, saturated once the quotient reaches one, else root
	always_comb begin
		if (undef_q) begin
			results.correlation = '0;
		end else if (d_q[DSTEP-1]) begin
			results.correlation = neg_q ? {1'b1, {QF{1'b0}}} : {1'b0, {QF{1'b1}}};
		end else begin
			results.correlation = neg_q ? (16'(0) - {1'b0, root_q}) : {1'b0, root_q};
		end
	end

	assign results.valid     = (state_q == mrc_pkg::ST_DONE);
	assign results.undefined = undef_q;

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.undefined |-> results.correlation == '0)
		else $error("undefined item with non-zero correlation");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == mrc_pkg::ST_IDLE && nonempty)
		else $error("queue popped while busy");

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrc_pkg::ST_DONE && !undef_q && !d_q[DSTEP-1])
		|-> root_sq <= d_q[SHIFT-1:0])
		else $error("square root too large");

	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mrc_pkg::ST_DIV && $past(state_q) == mrc_pkg::ST_MUL
		|-> cnt_q == CNTB'(DSTEP))
		else $error("division step count not loaded");

endmodule

/* rtl/core/masked_residual_correlation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_residual_correlation
// streaming Pearson correlation of two masked residual streams, Q1.15 result
// ----------------------------------------------------------------------------
// throughput: one site item per cycle within a pair; the back end takes one pair at a time
//   and pops the next only once idle; sites stall while the two-entry queue is full
//   or its last free entry is about to be taken by a pending push
// a result passes the front stage and the queue, then the multiply, divide and root steps
// an undefined result skips the multiply, divide and root steps
// reset clears means, accumulators, queue and state; no clearing pass
module masked_residual_correlation #(
	parameter int SITE_COUNT_BITS = mrc_pkg::DEF_SITE_COUNT_BITS,
	parameter int FRAC_BITS       = mrc_pkg::DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mrc_in_if.sink               sites,
	mrc_out_if.source            results,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [FRAC_BITS+1:0] cfg_data
);
	localparam int SQ = mrc_pkg::sq_bits(FRAC_BITS, SITE_COUNT_BITS);
	localparam int CB = SQ + 1;
	localparam int QW = CB + 2 * SQ;
	localparam int FB = $clog2(mrc_pkg::QUEUE_DEPTH + 1);

	logic          push, pop, nonempty;
	logic [FB-1:0] free;
	logic [CB-1:0] f_cross, b_cross;
	logic [SQ-1:0] f_sq_a, f_sq_b, b_sq_a, b_sq_b;

	mrc_front #(
		.SITE_COUNT_BITS(SITE_COUNT_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sites(sites),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.free(free),
		.push(push),
		.sum_cross(f_cross),
		.sum_sq_a(f_sq_a),
		.sum_sq_b(f_sq_b)
	);

	mrc_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din({f_cross, f_sq_a, f_sq_b}),
		.pop(pop),
		.dout({b_cross, b_sq_a, b_sq_b}),
		.nonempty(nonempty),
		.free(free)
	);

	mrc_back #(
		.SITE_COUNT_BITS(SITE_COUNT_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.nonempty(nonempty),
		.sum_cross(b_cross),
		.sum_sq_a(b_sq_a),
		.sum_sq_b(b_sq_b),
		.pop(pop),
		.results(results)
	);

endmodule
